FILE: design/cfla_pkg.sv
// Shared types and codes for the coalescing free-list allocator.
`default_nettype none
package cfla_pkg;

  // One free extent as held in the table.
  typedef struct packed {
    logic [31:0] blk;
    logic [15:0] off;
    logic [31:0] len;
  } entry_t;

  // A position: block number and byte offset.
  typedef struct packed {
    logic [31:0] blk;
    logic [15:0] off;
  } pos_t;

  // Request codes.
  localparam logic OP_FREE  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_FREED   = 2'd0;
  localparam logic [1:0] ST_ALLOC   = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Configuration register indexes.
  localparam logic REG_DATA_BEGIN = 1'b0;
  localparam logic REG_DATA_END   = 1'b1;

  // Width of the reported entry count.
  localparam int CNT_W = 7;

endpackage
`default_nettype wire

FILE: design/cfla_if.sv
// Request and result channel interfaces of the allocator.
`default_nettype none
interface cfla_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] block_number;
  logic [15:0] byte_offset;
  logic [31:0] extent_length;
  modport source (output valid, opcode, block_number, byte_offset, extent_length,
                  input ready);
  modport sink (input valid, opcode, block_number, byte_offset, extent_length,
                output ready);
endinterface

interface cfla_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] out_block;
  logic [15:0] out_offset;
  logic        table_modified;
  logic [6:0]  entry_count;
  modport source (output valid, status, out_block, out_offset, table_modified,
                  entry_count, input ready);
  modport sink (input valid, status, out_block, out_offset, table_modified,
                entry_count, output ready);
endinterface
`default_nettype wire

FILE: design/coalescing_free_list_allocator_top.sv
// Top level of the coalescing free-list allocator: sequencer, table RAM and advance unit.
// One request is handled at a time. A request walks the sorted extent table in the
// RAM with a read and a check per entry, and may then shift entries with a read and a
// write per entry; each position advance runs in the shared divider unit. A request
// is shortest for an ignored free or exact reuse of the deferred extent, and longest
// when an insert with coalescing and a full search both run. The request channel is
// ready only between requests; the result word sits in an output register so the
// next request can be taken while it waits. No clearing pass is needed after reset.
`default_nettype none
module coalescing_free_list_allocator_top import cfla_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  cfla_req_if.sink    in_req,
  cfla_rsp_if.source  out_rsp,
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire  [15:0] cfg_wdata
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_SC_RD  = 5'd2;
  localparam logic [4:0] S_SC_CK  = 5'd3;
  localparam logic [4:0] S_MP_GO  = 5'd4;
  localparam logic [4:0] S_MP_WT  = 5'd5;
  localparam logic [4:0] S_MN_GO  = 5'd6;
  localparam logic [4:0] S_MN_WT  = 5'd7;
  localparam logic [4:0] S_DECIDE = 5'd8;
  localparam logic [4:0] S_SH_RD  = 5'd9;
  localparam logic [4:0] S_SH_WR  = 5'd10;
  localparam logic [4:0] S_WR_POS = 5'd11;
  localparam logic [4:0] S_INS_OK = 5'd12;
  localparam logic [4:0] S_FS_RD  = 5'd13;
  localparam logic [4:0] S_FS_CK  = 5'd14;
  localparam logic [4:0] S_AL_WT  = 5'd15;
  localparam logic [4:0] S_DONE   = 5'd16;

  logic [4:0]    state_r;
  logic [15:0]   data_begin_r, data_end_r;
  logic          op_r;
  logic [31:0]   in_blk_r, len_r;
  logic [15:0]   in_off_r;
  logic          pend_valid_r;
  entry_t        pend_r;
  logic          changed_r;
  logic [CW-1:0] n_r, idx_r, pos_r, sh_i_r, lim_r;
  logic          sh_down_r, phase_r;
  logic          have_prev_r, have_next_r, mprev_r, mnext_r;
  entry_t        prev_r, next_r, acc_r;
  logic [31:0]   tmp_len_r;
  logic [1:0]    status_r;
  logic [31:0]   ob_r;
  logic [15:0]   oo_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [31:0]   out_blk_r;
  logic [15:0]   out_off_r;
  logic          out_mod_r;
  logic [6:0]    out_cnt_r;

  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, rd;
  logic          adv_start, adv_done;
  pos_t          adv_pos, adv_res;
  logic [31:0]   adv_len;

  logic [CW-1:0] idx_inc, sh_inc, sh_dec, pos_dec;
  logic [CW+6:0] n_ext;
  logic          ins_fail, key_lt, fit_hit, fit_eq;
  logic [32:0]   prev_sum, next_sum;

  cfla_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  cfla_adv u_adv (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (adv_start),
    .pos_i      (adv_pos),
    .len_i      (adv_len),
    .data_begin (data_begin_r),
    .data_end   (data_end_r),
    .done       (adv_done),
    .pos_o      (adv_res)
  );

  // Counters, comparisons and length sums used by the sequencer.
  always_comb begin
    idx_inc  = idx_r + CW'(1);
    sh_inc   = sh_i_r + CW'(1);
    sh_dec   = sh_i_r - CW'(1);
    pos_dec  = pos_r - CW'(1);
    n_ext    = {7'd0, n_r};
    key_lt   = {pend_r.blk, pend_r.off} < {rd.blk, rd.off};
    fit_hit  = rd.len >= len_r;
    fit_eq   = rd.len == len_r;
    prev_sum = {1'b0, prev_r.len} + {1'b0, pend_r.len};
    next_sum = {1'b0, acc_r.len} + {1'b0, next_r.len};
    ins_fail = !mprev_r && !mnext_r && (n_r >= CW'(TABLE_DEPTH));
  end

  // RAM and advance unit control decoded from the state.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r[IW-1:0];
    ram_wdata = acc_r;
    ram_raddr = idx_r[IW-1:0];
    adv_start = 1'b0;
    adv_pos   = {acc_r.blk, acc_r.off};
    adv_len   = acc_r.len;
    unique case (state_r)
      S_SH_RD: begin
        ram_raddr = sh_down_r ? sh_inc[IW-1:0] : sh_dec[IW-1:0];
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = sh_i_r[IW-1:0];
        ram_wdata = rd;
      end
      S_DECIDE: begin
        if (!ins_fail && mprev_r) begin
          ram_we    = 1'b1;
          ram_waddr = pos_dec[IW-1:0];
        end else if (!ins_fail && mnext_r) begin
          ram_we    = 1'b1;
          ram_waddr = pos_r[IW-1:0];
        end
      end
      S_WR_POS: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r[IW-1:0];
      end
      S_MP_GO: begin
        adv_start = have_prev_r;
        adv_pos   = {prev_r.blk, prev_r.off};
        adv_len   = prev_r.len;
      end
      S_MN_GO: begin
        adv_start = have_next_r;
      end
      S_FS_CK: begin
        adv_start = fit_hit && !fit_eq;
        adv_pos   = {rd.blk, rd.off};
        adv_len   = len_r;
      end
      S_AL_WT: begin
        ram_we    = adv_done;
        ram_wdata = {adv_res.blk, adv_res.off, tmp_len_r};
      end
      default: begin
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_begin_r <= 16'd0;
      data_end_r   <= 16'd8192;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DATA_BEGIN: data_begin_r <= cfg_wdata;
        REG_DATA_END:   data_end_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_valid_r <= 1'b0;
      changed_r    <= 1'b0;
      n_r          <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // The output register fills from the done step and empties when taken.
      if (state_r == S_DONE && (!out_valid_r || out_rsp.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_req.valid) begin
            op_r     <= in_req.opcode;
            in_blk_r <= in_req.block_number;
            in_off_r <= in_req.byte_offset;
            len_r    <= in_req.extent_length;
            state_r  <= S_DISP;
          end
        end
        S_DISP: begin
          idx_r       <= '0;
          acc_r       <= pend_r;
          have_prev_r <= 1'b0;
          have_next_r <= 1'b0;
          mprev_r     <= 1'b0;
          mnext_r     <= 1'b0;
          pos_r       <= '0;
          if (op_r == OP_FREE && len_r == 32'd0) begin
            status_r <= ST_FREED;
            ob_r     <= '0;
            oo_r     <= '0;
            phase_r  <= 1'b0;
            state_r  <= S_DONE;
          end else if (op_r == OP_ALLOC && pend_valid_r && pend_r.len == len_r) begin
            status_r     <= ST_ALLOC;
            ob_r         <= pend_r.blk;
            oo_r         <= pend_r.off;
            phase_r      <= 1'b0;
            pend_valid_r <= 1'b0;
            state_r      <= S_DONE;
          end else if (pend_valid_r) begin
            // Push the deferred extent into the table first.
            status_r <= ST_FREED;
            ob_r     <= '0;
            oo_r     <= '0;
            phase_r  <= 1'b0;
            state_r  <= (n_r == '0) ? S_MP_GO : S_SC_RD;
          end else if (op_r == OP_FREE) begin
            status_r     <= ST_FREED;
            ob_r         <= '0;
            oo_r         <= '0;
            phase_r      <= 1'b0;
            pend_valid_r <= 1'b1;
            pend_r       <= {in_blk_r, in_off_r, len_r};
            state_r      <= S_DONE;
          end else begin
            ob_r     <= '0;
            oo_r     <= '0;
            phase_r  <= 1'b1;
            status_r <= ST_NOSPACE;
            state_r  <= (n_r == '0) ? S_DONE : S_FS_RD;
          end
        end
        S_SC_RD: begin
          state_r <= S_SC_CK;
        end
        S_SC_CK: begin
          // The last entry that sorts before the new one becomes the lower neighbour.
          if (key_lt) begin
            pos_r       <= idx_r;
            next_r      <= rd;
            have_next_r <= 1'b1;
            state_r     <= S_MP_GO;
          end else begin
            prev_r      <= rd;
            have_prev_r <= 1'b1;
            idx_r       <= idx_inc;
            if (idx_inc == n_r) begin
              pos_r   <= n_r;
              state_r <= S_MP_GO;
            end else begin
              state_r <= S_SC_RD;
            end
          end
        end
        S_MP_GO: begin
          state_r <= have_prev_r ? S_MP_WT : S_MN_GO;
        end
        S_MP_WT: begin
          if (adv_done) begin
            if (adv_res == {pend_r.blk, pend_r.off} && !prev_sum[32]) begin
              mprev_r <= 1'b1;
              acc_r   <= {prev_r.blk, prev_r.off, prev_sum[31:0]};
            end
            state_r <= S_MN_GO;
          end
        end
        S_MN_GO: begin
          state_r <= have_next_r ? S_MN_WT : S_DECIDE;
        end
        S_MN_WT: begin
          if (adv_done) begin
            if (adv_res == {next_r.blk, next_r.off} && !next_sum[32]) begin
              mnext_r   <= 1'b1;
              acc_r.len <= next_sum[31:0];
            end
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (ins_fail) begin
            status_r <= ST_FULL;
            state_r  <= S_DONE;
          end else if (mprev_r && mnext_r) begin
            // Lower neighbour absorbs both; close the gap left by the upper one.
            n_r       <= n_r - CW'(1);
            lim_r     <= n_r - CW'(1);
            sh_i_r    <= pos_r;
            sh_down_r <= 1'b1;
            state_r   <= ((pos_r + CW'(1)) < n_r) ? S_SH_RD : S_INS_OK;
          end else if (mprev_r || mnext_r) begin
            state_r <= S_INS_OK;
          end else begin
            // Open a slot at the insert point by moving the tail up one entry.
            n_r       <= n_r + CW'(1);
            sh_i_r    <= n_r;
            sh_down_r <= 1'b0;
            state_r   <= (n_r > pos_r) ? S_SH_RD : S_WR_POS;
          end
        end
        S_SH_RD: begin
          state_r <= S_SH_WR;
        end
        S_SH_WR: begin
          if (sh_down_r) begin
            sh_i_r <= sh_inc;
            if (sh_inc < lim_r) begin
              state_r <= S_SH_RD;
            end else begin
              state_r <= phase_r ? S_DONE : S_INS_OK;
            end
          end else begin
            sh_i_r  <= sh_dec;
            state_r <= (sh_dec > pos_r) ? S_SH_RD : S_WR_POS;
          end
        end
        S_WR_POS: begin
          state_r <= S_INS_OK;
        end
        S_INS_OK: begin
          changed_r <= 1'b1;
          if (op_r == OP_FREE) begin
            pend_r  <= {in_blk_r, in_off_r, len_r};
            state_r <= S_DONE;
          end else begin
            pend_valid_r <= 1'b0;
            phase_r      <= 1'b1;
            idx_r        <= '0;
            status_r     <= ST_NOSPACE;
            state_r      <= (n_r == '0) ? S_DONE : S_FS_RD;
          end
        end
        S_FS_RD: begin
          state_r <= S_FS_CK;
        end
        S_FS_CK: begin
          // First fit: take the entry whole or shrink it from the front.
          if (fit_hit) begin
            status_r  <= ST_ALLOC;
            ob_r      <= rd.blk;
            oo_r      <= rd.off;
            changed_r <= 1'b1;
            tmp_len_r <= rd.len - len_r;
            if (fit_eq) begin
              n_r       <= n_r - CW'(1);
              lim_r     <= n_r - CW'(1);
              sh_i_r    <= idx_r;
              sh_down_r <= 1'b1;
              state_r   <= (idx_inc < n_r) ? S_SH_RD : S_DONE;
            end else begin
              state_r <= S_AL_WT;
            end
          end else begin
            idx_r   <= idx_inc;
            state_r <= (idx_inc == n_r) ? S_DONE : S_FS_RD;
          end
        end
        S_AL_WT: begin
          if (adv_done) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // Hand the result word to the output register once it is free.
          if (!out_valid_r || out_rsp.ready) begin
            out_status_r <= status_r;
            out_blk_r    <= ob_r;
            out_off_r    <= oo_r;
            out_mod_r    <= changed_r;
            out_cnt_r    <= n_ext[CNT_W-1:0];
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_req.ready           = (state_r == S_IDLE);
  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.status         = out_status_r;
  assign out_rsp.out_block      = out_blk_r;
  assign out_rsp.out_offset     = out_off_r;
  assign out_rsp.table_modified = out_mod_r;
  assign out_rsp.entry_count    = out_cnt_r;

  // The table never holds more entries than it has rows.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // The modified flag is sticky.
  a_mod_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(changed_r))
    else $error("modified flag cleared");

  // An accepted request word starts the dispatch step.
  a_accept_disp: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> state_r == S_DISP)
    else $error("accepted word not dispatched");

  // A table write never happens while the sequencer is idle or reporting.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !ram_we)
    else $error("table written outside a request");

endmodule
`default_nettype wire

FILE: design/cfla_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/cfla_adv.sv
// Position advance unit: adds a length to a position and wraps it across blocks.
`default_nettype none
module cfla_adv import cfla_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  input  pos_t        pos_i,
  input  wire  [31:0] len_i,
  input  wire  [15:0] data_begin,
  input  wire  [15:0] data_end,
  output logic        done,
  output pos_t        pos_o
);

  localparam int DivSteps = 33;

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [15:0] rem_r;
  logic [32:0] quo_r;
  logic [31:0] blk_r;
  logic [15:0] size_r;
  logic [15:0] begin_r;
  logic        done_r;
  pos_t        pos_r;

  logic [32:0] sum;
  logic [15:0] size;
  logic [16:0] trial;
  logic        ge;
  logic [16:0] diff;

  // Sum of offset and length, and the size of the usable area.
  always_comb begin
    sum   = {17'd0, pos_i.off} + {1'b0, len_i};
    size  = (data_end > data_begin) ? (data_end - data_begin) : 16'd0;
    trial = {rem_r, quo_r[32]};
    ge    = trial >= {1'b0, size_r};
    diff  = trial - {1'b0, size_r};
  end

  // Restoring division of the overshoot by the area size, one bit a cycle.
  // The quotient plus one is the number of blocks stepped; the remainder
  // plus data_begin is the new offset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // Done pulses for one cycle on the fast path or at the end of the division.
      done_r <= (start && (size == 16'd0 || sum < {17'd0, data_end})) ||
                (!start && busy_r && cnt_r == 6'd0);
      if (start) begin
        if (size == 16'd0 || sum < {17'd0, data_end}) begin
          pos_r.blk <= pos_i.blk;
          pos_r.off <= sum[15:0];
        end else begin
          busy_r  <= 1'b1;
          cnt_r   <= 6'(DivSteps);
          quo_r   <= sum - {17'd0, data_end};
          rem_r   <= '0;
          blk_r   <= pos_i.blk;
          size_r  <= size;
          begin_r <= data_begin;
        end
      end else if (busy_r) begin
        if (cnt_r == 6'd0) begin
          pos_r.blk <= blk_r + quo_r[31:0] + 32'd1;
          pos_r.off <= rem_r + begin_r;
          busy_r    <= 1'b0;
        end else begin
          rem_r <= ge ? diff[15:0] : trial[15:0];
          quo_r <= {quo_r[31:0], ge};
          cnt_r <= cnt_r - 6'd1;
        end
      end
    end
  end

  assign done  = done_r;
  assign pos_o = pos_r;

endmodule
`default_nettype wire
